// File: hdl/ibpd_pkg.sv
// ibpd_pkg: sizes, register codes, rule layout and shared types of the
// input burst pause detector; used by the channel interfaces and all modules
`default_nettype none

package ibpd_pkg;

   localparam int HISTORY_DEPTH    = 32;
   localparam int RULES_PER_SOURCE = 2;
   localparam int SOURCE_COUNT     = 3;

   localparam int STAMP_W     = 32;
   localparam int PAUSE_W     = 16;
   localparam int SRC_W       = 2;
   localparam int HITS_W      = 2;
   localparam int CAP_W       = 6;
   localparam int COUNT_W     = 6;
   localparam int WINDOW_W    = 20;
   localparam int CSR_DATA_W  = 43;
   localparam int CSR_INDEX_W = 3;

   localparam int NUM_RULE_REGS = 6;
   localparam int RULE_SLOTS    = 2;
   localparam int RULE_IDX_W    = $clog2(NUM_RULE_REGS);

   localparam int CAP_RESET = 32;
   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
   localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
   localparam int NUM_W     = (FILL_W + 1 > COUNT_W + 1) ? FILL_W + 1 : COUNT_W + 1;
   localparam int RING_W    = $clog2(HISTORY_DEPTH + COUNT_MAX + 1);
   localparam int ADDR_W    = $clog2(SOURCE_COUNT * HISTORY_DEPTH);
   localparam int SRC_IDX_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAPACITY = 3'd0,
      CSR_KBD_A    = 3'd1,
      CSR_KBD_B    = 3'd2,
      CSR_MOUSE_A  = 3'd3,
      CSR_MOUSE_B  = 3'd4,
      CSR_ANY_A    = 3'd5,
      CSR_ANY_B    = 3'd6
   } csr_index_type;

   typedef enum logic {
      CMD_EVENT     = 1'b0,
      CMD_SET_PAUSE = 1'b1
   } command_type;

   typedef struct packed {
      logic                enable;
      logic [COUNT_W-1:0]  count;
      logic [WINDOW_W-1:0] window;
      logic [PAUSE_W-1:0]  pause;
   } rule_type;

   // oldest stamp of each rule's window and whether the rule may fire
   typedef struct packed {
      logic [RULES_PER_SOURCE-1:0]              armed;
      logic [RULES_PER_SOURCE-1:0][STAMP_W-1:0] oldest;
   } hist_type;

   function automatic logic [RULE_IDX_W-1:0] rule_index(input logic [SRC_W-1:0] src,
                                                        input int rule);
      return RULE_IDX_W'(int'(src) * RULE_SLOTS + rule);
   endfunction

endpackage

`default_nettype wire

// File: hdl/ibpd_if.sv
// ibpd_req_if, ibpd_rsp_if: valid/ready channels of the detector
// depends on ibpd_pkg for field widths
`default_nettype none

interface ibpd_req_if;
   import ibpd_pkg::*;
   logic               valid;
   logic               ready;
   logic               command;
   logic [SRC_W-1:0]   source_kind;
   logic [STAMP_W-1:0] stamp_ms;
   logic [PAUSE_W-1:0] new_pause;
   modport source(output valid, command, source_kind, stamp_ms, new_pause, input ready);
   modport sink(input valid, command, source_kind, stamp_ms, new_pause, output ready);
endinterface

interface ibpd_rsp_if;
   import ibpd_pkg::*;
   logic               valid;
   logic               ready;
   logic [PAUSE_W-1:0] pause_value;
   logic               raised;
   logic [HITS_W-1:0]  rule_hits;
   modport source(output valid, pause_value, raised, rule_hits, input ready);
   modport sink(input valid, pause_value, raised, rule_hits, output ready);
endinterface

`default_nettype wire

// File: hdl/ibpd_history.sv
// ibpd_history: per-source stamp rings, fill counts and write slots;
// looks up the oldest stamp of each rule window; depends on ibpd_pkg
`default_nettype none

module ibpd_history (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         load,
   input  logic                                         write_en,
   input  logic [ibpd_pkg::SRC_W-1:0]                   src,
   input  logic [ibpd_pkg::STAMP_W-1:0]                 stamp,
   input  logic [ibpd_pkg::CAP_W-1:0]                   capacity,
   input  ibpd_pkg::rule_type [ibpd_pkg::RULES_PER_SOURCE-1:0] rules,
   output ibpd_pkg::hist_type                           hist
);
   import ibpd_pkg::*;

   logic [STAMP_W-1:0] mem [SOURCE_COUNT*HISTORY_DEPTH];
   logic [FILL_W-1:0]  fill_ff [SOURCE_COUNT];
   logic [SLOT_W-1:0]  slot_ff [SOURCE_COUNT];
   hist_type           hist_ff;

   logic [SRC_IDX_W-1:0]        src_idx;
   logic [NUM_W-1:0]            cap_eff;
   logic [NUM_W-1:0]            nf;
   logic [FILL_W-1:0]           fill_in;
   logic [SLOT_W-1:0]           slot_in;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ADDR_W-1:0]           rd_addr [RULES_PER_SOURCE];
   logic [RULES_PER_SOURCE-1:0] armed_in;
   logic [RULES_PER_SOURCE-1:0] self_in;

   function automatic logic [SLOT_W-1:0] ring_back(input logic [SLOT_W-1:0] slot,
                                                   input logic [COUNT_W-1:0] back);
      logic [RING_W-1:0] s;
      logic [RING_W-1:0] b;
      logic [RING_W-1:0] t;
      s = RING_W'(slot);
      b = RING_W'(back);
      t = (s >= b) ? s - b : s + RING_W'(HISTORY_DEPTH) - b;
      return t[SLOT_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [SRC_IDX_W-1:0] s,
                                                  input logic [SLOT_W-1:0] slot);
      return ADDR_W'(s) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(slot);
   endfunction

   always_comb begin
      src_idx = write_en ? src[SRC_IDX_W-1:0] : '0;
      cap_eff = (NUM_W'(capacity) > NUM_W'(HISTORY_DEPTH)) ? NUM_W'(HISTORY_DEPTH)
                                                            : NUM_W'(capacity);
      nf = NUM_W'(fill_ff[src_idx]) + NUM_W'(1);
      if (nf > cap_eff) nf = NUM_W'(fill_ff[src_idx]);
      if (nf > NUM_W'(HISTORY_DEPTH)) nf = NUM_W'(HISTORY_DEPTH);
      if (cap_eff == '0) nf = '0;
      fill_in = FILL_W'(nf);
      slot_in = (slot_ff[src_idx] == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                 : slot_ff[src_idx] + SLOT_W'(1);
      wr_addr = mem_addr(src_idx, slot_ff[src_idx]);
      for (int r = 0; r < RULES_PER_SOURCE; r++) begin
         rd_addr[r]  = mem_addr(src_idx,
                                ring_back(slot_ff[src_idx], rules[r].count - COUNT_W'(1)));
         armed_in[r] = write_en && rules[r].enable && (rules[r].count != '0)
                       && (NUM_W'(rules[r].count) <= nf);
         // a window of one stamp is the stamp being written
         self_in[r]  = (rules[r].count == COUNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[wr_addr] <= stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int r = 0; r < RULES_PER_SOURCE; r++) begin
            hist_ff.armed[r]  <= armed_in[r];
            hist_ff.oldest[r] <= self_in[r] ? stamp : mem[rd_addr[r]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SOURCE_COUNT; s++) begin
            fill_ff[s] <= '0;
            slot_ff[s] <= '0;
         end
      end else if (write_en) begin
         fill_ff[src_idx] <= fill_in;
         slot_ff[src_idx] <= slot_in;
      end
   end

   assign hist = hist_ff;

endmodule

`default_nettype wire

// File: hdl/input_burst_pause_detector_core.sv
// input_burst_pause_detector_core: top level of the burst pause detector
// depends on ibpd_pkg, ibpd_if and ibpd_history
//
// Each event stamp goes into its source's history ring; each enabled rule of
// that source fires when its count of newest stamps spans at most its window,
// and a firing rule raises the held pause to the rule's pause. A set-pause
// command overwrites the held pause. One item is taken per clock while results
// are taken; a result passes the lookup stage, whose read of the history memory
// is registered, and then the output register, which lets the next item in
// while a result waits. The history memory needs no clearing after reset: the
// per-source fill counts keep unwritten entries from being used. Write the
// configuration registers only while the block is idle.
`default_nettype none

module input_burst_pause_detector_core (
   input  logic                             clock,
   input  logic                             reset,
   ibpd_req_if.sink                         req_bus,
   ibpd_rsp_if.source                       rsp_bus,
   input  logic                             csr_write_enable,
   input  logic [ibpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ibpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ibpd_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   rule_type         rule_ff [NUM_RULE_REGS];

   logic               s1_valid_ff;
   logic               s1_cmd_ff;
   logic               s1_event_ff;
   logic [SRC_W-1:0]   s1_src_ff;
   logic [STAMP_W-1:0] s1_stamp_ff;
   logic [PAUSE_W-1:0] s1_new_pause_ff;

   logic [PAUSE_W-1:0] held_ff;
   logic               out_valid_ff;
   logic [PAUSE_W-1:0] out_pause_ff;
   logic               out_raised_ff;
   logic [HITS_W-1:0]  out_hits_ff;

   logic                                   accept;
   logic                                   s1_advance;
   logic                                   req_event;
   logic [SRC_W-1:0]                       req_src;
   rule_type [RULES_PER_SOURCE-1:0]        req_rules;
   hist_type                               hist;
   logic [PAUSE_W-1:0]                     pause_in;
   logic                                   raised_in;
   logic [HITS_W-1:0]                      hits_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(CAP_RESET);
         for (int i = 0; i < NUM_RULE_REGS; i++) begin
            rule_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CAPACITY: begin
               capacity_ff <= csr_wdata[CAP_W-1:0];
            end
            CSR_KBD_A, CSR_KBD_B, CSR_MOUSE_A, CSR_MOUSE_B, CSR_ANY_A, CSR_ANY_B: begin
               rule_ff[RULE_IDX_W'(csr_index - CSR_INDEX_W'(CSR_KBD_A))] <= rule_type'(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   assign s1_advance    = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || !out_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      req_event = (req_bus.command == CMD_EVENT) && (int'(req_bus.source_kind) < SOURCE_COUNT);
      req_src   = req_event ? req_bus.source_kind : '0;
      for (int r = 0; r < RULES_PER_SOURCE; r++) begin
         req_rules[r] = rule_ff[rule_index(req_src, r)];
      end
   end

   ibpd_history u_history (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .write_en (accept && req_event),
      .src      (req_src),
      .stamp    (req_bus.stamp_ms),
      .capacity (capacity_ff),
      .rules    (req_rules),
      .hist     (hist)
   );

   // transfer into the lookup stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff       <= req_bus.command;
         s1_event_ff     <= req_event;
         s1_src_ff       <= req_src;
         s1_stamp_ff     <= req_bus.stamp_ms;
         s1_new_pause_ff <= req_bus.new_pause;
      end
   end

   // window compare and pause update
   always_comb begin
      rule_type     rule;
      logic [STAMP_W-1:0] diff;
      rule     = '0;
      diff     = '0;
      pause_in = held_ff;
      hits_in  = '0;
      if (s1_cmd_ff == CMD_SET_PAUSE) begin
         pause_in = s1_new_pause_ff;
      end else if (s1_event_ff) begin
         for (int r = 0; r < RULES_PER_SOURCE; r++) begin
            rule = rule_ff[rule_index(s1_src_ff, r)];
            diff = s1_stamp_ff - hist.oldest[r];
            if (hist.armed[r] && (diff <= STAMP_W'(rule.window))) begin
               hits_in[r] = 1'b1;
               if (pause_in < rule.pause) pause_in = rule.pause;
            end
         end
      end
      raised_in = s1_event_ff && (pause_in > held_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         held_ff      <= pause_in;
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_pause_ff  <= pause_in;
         out_raised_ff <= raised_in;
         out_hits_ff   <= hits_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.pause_value = out_pause_ff;
   assign rsp_bus.raised      = out_raised_ff;
   assign rsp_bus.rule_hits   = out_hits_ff;

endmodule

`default_nettype wire

// File: verif/tb_input_burst_pause_detector_core.sv
// tb_input_burst_pause_detector_core: self-checking bench for the burst pause detector core
// depends on ibpd_pkg, ibpd_if and the core; a queue-fed driver and a monitor check each
// transfer against an in-bench predictor of history rings, rules and held pause
`timescale 1ns / 100ps

module tb_input_burst_pause_detector_core;
   import ibpd_pkg::*;

   localparam logic [SRC_W-1:0]       SRC_KEYBOARD    = 2'd0;
   localparam logic [SRC_W-1:0]       SRC_MOUSE       = 2'd1;
   localparam logic [SRC_W-1:0]       SRC_COMBINED    = 2'd2;
   localparam logic [SRC_W-1:0]       SRC_UNUSED      = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int SEGMENT_ITEMS  = 200;
   localparam int SEGMENT_COUNT  = 8;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      command_type         command;
      logic [SRC_W-1:0]    source_kind;
      logic [STAMP_W-1:0]  stamp_ms;
      logic [PAUSE_W-1:0]  new_pause;
   } event_item_type;

   typedef struct packed {
      logic [PAUSE_W-1:0] pause_value;
      logic               raised;
      logic [HITS_W-1:0]  rule_hits;
   } pause_result_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ibpd_req_if req_bus();
   ibpd_rsp_if rsp_bus();

   input_burst_pause_detector_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // predictor state
   logic [STAMP_W-1:0] stamp_ring [SOURCE_COUNT][HISTORY_DEPTH];
   logic [FILL_W-1:0]  ring_fill [SOURCE_COUNT];
   logic [SLOT_W-1:0]  ring_slot [SOURCE_COUNT];
   logic [PAUSE_W-1:0] pause_held;
   logic [CAP_W-1:0]   capacity_reg;
   rule_type           rule_reg [NUM_RULE_REGS];

   event_item_type   pending_items[$];
   pause_result_type pause_expected[$];
   event_item_type   driven_item;
   pause_result_type want_result;
   logic [STAMP_W-1:0] stamp_cursor;
   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int idle_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic model_reset();
      capacity_reg = CAP_W'(CAP_RESET);
      pause_held   = '0;
      for (int s = 0; s < SOURCE_COUNT; s++) begin
         ring_fill[s] = '0;
         ring_slot[s] = '0;
         for (int d = 0; d < HISTORY_DEPTH; d++) stamp_ring[s][d] = '0;
      end
      for (int r = 0; r < NUM_RULE_REGS; r++) rule_reg[r] = '0;
   endtask

   function automatic pause_result_type predict_pause(event_item_type it);
      pause_result_type res;
      rule_type rl;
      logic [PAUSE_W-1:0] prior;
      logic [STAMP_W-1:0] span;
      int src, cap_now, nf, slot_now, newest, oldest;
      res.raised    = 1'b0;
      res.rule_hits = '0;
      if (it.command == CMD_SET_PAUSE) begin
         pause_held = it.new_pause;
      end else if (int'(it.source_kind) < SOURCE_COUNT) begin
         src = int'(it.source_kind);
         cap_now = (int'(capacity_reg) > HISTORY_DEPTH) ? HISTORY_DEPTH : int'(capacity_reg);
         prior = pause_held;
         slot_now = int'(ring_slot[src]);
         stamp_ring[src][slot_now] = it.stamp_ms;
         slot_now = (slot_now + 1) % HISTORY_DEPTH;
         ring_slot[src] = SLOT_W'(slot_now);
         nf = int'(ring_fill[src]) + 1;
         if (nf > cap_now) nf = int'(ring_fill[src]);
         if (nf > HISTORY_DEPTH) nf = HISTORY_DEPTH;
         if (nf > cap_now && cap_now == 0) nf = 0;
         ring_fill[src] = FILL_W'(nf);
         for (int r = 0; r < RULES_PER_SOURCE; r++) begin
            rl = rule_reg[src * RULE_SLOTS + r];
            if (rl.enable && rl.count != 0 && int'(rl.count) <= int'(ring_fill[src])) begin
               newest = (slot_now + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
               oldest = (slot_now + HISTORY_DEPTH - int'(rl.count)) % HISTORY_DEPTH;
               span = stamp_ring[src][newest] - stamp_ring[src][oldest];
               if (span <= STAMP_W'(rl.window)) begin
                  res.rule_hits[r] = 1'b1;
                  if (pause_held < rl.pause) pause_held = rl.pause;
               end
            end
         end
         res.raised = (pause_held > prior);
      end
      res.pause_value = pause_held;
      return res;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      mismatch_count++;
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      if (idx == CSR_CAPACITY) capacity_reg = data[CAP_W-1:0];
      else if (idx <= CSR_ANY_B) rule_reg[int'(idx) - 1] = rule_type'(data);
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic rule_type make_rule(logic en, int cnt, int win, int pause);
      rule_type rl;
      rl.enable = en;
      rl.count  = COUNT_W'(cnt);
      rl.window = WINDOW_W'(win);
      rl.pause  = PAUSE_W'(pause);
      return rl;
   endfunction

   function automatic rule_type rand_rule(int cap_eff);
      rule_type rl;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return rule_type'(CSR_DATA_W'({$urandom, $urandom}));
      rl.enable = (pick >= 15);
      pick = $urandom_range(0, 99);
      if (pick < 5) rl.count = '0;
      else if (pick < 10) rl.count = COUNT_W'($urandom_range(33, 63));
      else if (pick < 55) rl.count = COUNT_W'($urandom_range(1, (cap_eff < 6) ? cap_eff : 6));
      else rl.count = COUNT_W'($urandom_range(1, cap_eff));
      pick = $urandom_range(0, 99);
      if (pick < 5) rl.window = '0;
      else if (pick < 10) rl.window = '1;
      else rl.window = WINDOW_W'($urandom_range(0, 4000));
      rl.pause = PAUSE_W'($urandom);
      return rl;
   endfunction

   function automatic void queue_item(command_type c, logic [SRC_W-1:0] s,
                                      logic [STAMP_W-1:0] t, logic [PAUSE_W-1:0] p);
      event_item_type it;
      it.command     = c;
      it.source_kind = s;
      it.stamp_ms    = t;
      it.new_pause   = p;
      pending_items = {pending_items, it};
   endfunction

   function automatic event_item_type build_random_item();
      event_item_type it;
      int pick;
      it.command     = CMD_EVENT;
      it.source_kind = SRC_W'($urandom_range(0, 2));
      it.stamp_ms    = $urandom;
      it.new_pause   = PAUSE_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         it.command = CMD_SET_PAUSE;
         if ($urandom_range(0, 1)) it.new_pause = PAUSE_W'($urandom_range(0, 40));
      end else if (pick < 11) begin
         it.source_kind = SRC_UNUSED;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 2) stamp_cursor = $urandom;
         else if (pick < 4) stamp_cursor = 32'hFFFF_FFFF - $urandom_range(0, 800);
         else if (pick < 10) stamp_cursor = stamp_cursor + $urandom_range(0, 20000);
         else stamp_cursor = stamp_cursor + $urandom_range(0, 400);
         it.stamp_ms = stamp_cursor;
      end
      return it;
   endfunction

   // sampled away from the rising edge so every transfer of that edge is settled
   task automatic wait_idle();
      @(negedge clock);
      while (pending_items.size() != 0 || pause_expected.size() != 0 || req_bus.valid)
         @(negedge clock);
   endtask

   task automatic directed_config(logic [CAP_W-1:0] cap);
      write_reg(CSR_SPARE_INDEX, '1);
      write_reg(CSR_CAPACITY, CSR_DATA_W'(cap));
      write_reg(CSR_KBD_A,   make_rule(1'b1, 1, 0, 5));
      write_reg(CSR_KBD_B,   make_rule(1'b1, 3, 5000, 15));
      write_reg(CSR_MOUSE_A, make_rule(1'b0, 1, 20'hFFFFF, 16'hFFFF));
      write_reg(CSR_MOUSE_B, make_rule(1'b1, 2, 100, 200));
      write_reg(CSR_ANY_A,   make_rule(1'b1, 0, 20'hFFFFF, 16'hFFFF));
      write_reg(CSR_ANY_B,   make_rule(1'b1, 40, 20'hFFFFF, 16'h1234));
      end_writes();
   endtask

   task automatic segment_config(int seg);
      int cap, cap_eff;
      case (seg)
         0: cap = 1;
         1: cap = 32;
         2: cap = 0;
         3: cap = 63;
         5: cap = 2;
         6: cap = 33;
         default: cap = $urandom_range(0, 63);
      endcase
      cap_eff = (cap > HISTORY_DEPTH) ? HISTORY_DEPTH : ((cap < 1) ? 1 : cap);
      write_reg(CSR_CAPACITY, CSR_DATA_W'(cap));
      for (int i = CSR_KBD_A; i <= CSR_ANY_B; i++)
         write_reg(CSR_INDEX_W'(i), rand_rule(cap_eff));
      if (seg % 2 == 1) write_reg(CSR_SPARE_INDEX, CSR_DATA_W'({$urandom, $urandom}));
      end_writes();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            pause_expected = {pause_expected, predict_pause(driven_item)};
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               driven_item = pending_items.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.command     <= driven_item.command;
               req_bus.source_kind <= driven_item.source_kind;
               req_bus.stamp_ms    <= driven_item.stamp_ms;
               req_bus.new_pause   <= driven_item.new_pause;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pause_expected.size() == 0) begin
               report_mismatch("unexpected result", rsp_bus.pause_value, 0);
            end else begin
               want_result = pause_expected.pop_front();
               if (rsp_bus.pause_value !== want_result.pause_value)
                  report_mismatch("pause_value", rsp_bus.pause_value, want_result.pause_value);
               if (rsp_bus.raised !== want_result.raised)
                  report_mismatch("raised", rsp_bus.raised, want_result.raised);
               if (rsp_bus.rule_hits !== want_result.rule_hits)
                  report_mismatch("rule_hits", rsp_bus.rule_hits, want_result.rule_hits);
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.command     = 1'b0;
      req_bus.source_kind = '0;
      req_bus.stamp_ms    = '0;
      req_bus.new_pause   = '0;
      rsp_bus.ready       = 1'b0;
      mismatch_count      = 0;
      idle_cycles         = 0;
      stamp_cursor        = $urandom;
      send_idle_pct       = 11;
      recv_idle_pct       = 85;
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // capacity zero keeps an empty history empty
      directed_config(6'd0);
      queue_item(CMD_EVENT, SRC_KEYBOARD, 32'd100, 16'd0);
      queue_item(CMD_EVENT, SRC_KEYBOARD, 32'd200, 16'd0);
      queue_item(CMD_EVENT, SRC_UNUSED, 32'd0, 16'd0);
      wait_idle();

      // capacity above depth, window edges and stamp wrap
      directed_config(6'd63);
      queue_item(CMD_SET_PAUSE, SRC_KEYBOARD, 32'd0, 16'd0);
      queue_item(CMD_EVENT, SRC_KEYBOARD, 32'd0, 16'd0);
      queue_item(CMD_EVENT, SRC_KEYBOARD, 32'd1000, 16'd0);
      queue_item(CMD_EVENT, SRC_KEYBOARD, 32'd5000, 16'd0);
      queue_item(CMD_EVENT, SRC_KEYBOARD, 32'd5001, 16'd0);
      queue_item(CMD_SET_PAUSE, SRC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
      queue_item(CMD_SET_PAUSE, SRC_MOUSE, 32'd0, 16'd0);
      queue_item(CMD_EVENT, SRC_MOUSE, 32'hFFFF_FFC0, 16'd0);
      queue_item(CMD_EVENT, SRC_MOUSE, 32'h0000_0020, 16'd0);
      queue_item(CMD_EVENT, SRC_MOUSE, 32'h0000_0200, 16'd0);
      queue_item(CMD_EVENT, SRC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
      queue_item(CMD_EVENT, SRC_COMBINED, 32'hFFFF_FFFF, 16'hFFFF);
      queue_item(CMD_EVENT, SRC_COMBINED, 32'd0, 16'd0);
      queue_item(CMD_EVENT, SRC_KEYBOARD, 32'hFFFF_FFFF, 16'hFFFF);
      queue_item(CMD_SET_PAUSE, SRC_COMBINED, 32'd0, 16'hAAAA);
      queue_item(CMD_SET_PAUSE, SRC_KEYBOARD, 32'hFFFF_FFFF, 16'h5555);
      wait_idle();

      // capacity lowered below the fill count
      write_reg(CSR_CAPACITY, CSR_DATA_W'(2));
      end_writes();
      queue_item(CMD_SET_PAUSE, SRC_KEYBOARD, 32'd0, 16'd0);
      queue_item(CMD_EVENT, SRC_KEYBOARD, 32'd6000, 16'd0);
      queue_item(CMD_EVENT, SRC_KEYBOARD, 32'd6001, 16'd0);
      queue_item(CMD_EVENT, SRC_KEYBOARD, 32'd12000, 16'd0);
      wait_idle();

      for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
         if (seg < 3) begin
            send_idle_pct = 11;
            recv_idle_pct = 85;
         end else if (seg < 6) begin
            send_idle_pct = 85;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         segment_config(seg);
         for (int n = 0; n < SEGMENT_ITEMS; n++) pending_items = {pending_items, build_random_item()};
         wait_idle();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pause_expected.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: filelist.f
hdl/ibpd_pkg.sv
hdl/ibpd_if.sv
hdl/ibpd_history.sv
hdl/input_burst_pause_detector_core.sv
verif/tb_input_burst_pause_detector_core.sv
